[hw/rtl/kvc_pkg.sv]
// ----------------------------------------------------------------------------
// kvc_pkg
// Shared types and codes for the keyed variant cache policy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvc_pkg;

  typedef enum logic [1:0] {
    ACT_DIRECT  = 2'd0,
    ACT_REPLAY  = 2'd1,
    ACT_CAPTURE = 2'd2,
    ACT_ABORT   = 2'd3
  } action_t;

  localparam logic [1:0] CST_OK    = 2'd0;
  localparam logic [1:0] CST_ABORT = 2'd2;

  localparam logic [1:0] RUN_MAX = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/kvc_if.sv]
// ----------------------------------------------------------------------------
// kvc_if
// Request, response and configuration channels of the variant cache policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kvc_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_index;
  logic [63:0] fingerprint;
  logic        bypass;
  logic        replay_ok;
  logic [1:0]  capture_status;
  modport source (output valid, key_index, fingerprint, bypass, replay_ok,
                  capture_status, input ready);
  modport sink (input valid, key_index, fingerprint, bypass, replay_ok,
                capture_status, output ready);
endinterface

interface kvc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] slot;
  logic       evicted;
  logic [1:0] evicted_slot;
  logic       key_dead;
  modport source (output valid, action, slot, evicted, evicted_slot, key_dead,
                  input ready);
  modport sink (input valid, action, slot, evicted, evicted_slot, key_dead,
                output ready);
endinterface

interface kvc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hw/rtl/kvc_ctrl.sv]
// ----------------------------------------------------------------------------
// kvc_ctrl
// Sequencer: accept, row read, slot scan, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kvc_pkg::sts_t sts,
  output kvc_pkg::cmd_t cmd
);
  import kvc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (in_valid) state <= ST_READ;
        ST_READ:   state <= ST_SCAN;
        ST_SCAN:   if (sts.scan_last) state <= ST_DECIDE;
        ST_DECIDE: if (sts.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.load_req  = (state == ST_IDLE) && in_valid;
    cmd.scan_step = (state == ST_SCAN);
    cmd.commit    = (state == ST_DECIDE) && sts.out_free;
  end

endmodule

[hw/rtl/kvc_datapath.sv]
// ----------------------------------------------------------------------------
// kvc_datapath
// Per-key row memory, slot scan accumulators, decision logic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvc_datapath #(
  parameter int NUM_KEYS    = 256,
  parameter int VARIANT_CAP = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  kvc_pkg::cmd_t cmd,
  output kvc_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic [7:0]    in_key,
  input  logic [63:0]   in_print,
  input  logic          in_bypass,
  input  logic          in_replay_ok,
  input  logic [1:0]    in_cstat,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_action,
  output logic [1:0]    out_slot,
  output logic          out_evicted,
  output logic [1:0]    out_ev_slot,
  output logic          out_dead
);
  import kvc_pkg::*;

  localparam int DEPTH = (NUM_KEYS < 256) ? NUM_KEYS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (VARIANT_CAP > 1) ? $clog2(VARIANT_CAP) : 1;

  typedef struct packed {
    logic                         dead;
    logic [1:0]                   run;
    logic                         pvalid;
    logic [63:0]                  pprint;
    logic [VARIANT_CAP-1:0]       sv;
    logic [VARIANT_CAP-1:0][63:0] sp;
    logic [VARIANT_CAP-1:0][63:0] ss;
  } row_t;

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] live;
  row_t             rd_row;
  logic             rd_live;

  logic        enabled;
  logic [63:0] use_clock;

  // latched request
  logic [7:0]  key;
  logic [63:0] fp;
  logic        bypass;
  logic        replay_ok;
  logic [1:0]  cstat;
  logic [AW-1:0] addr;
  logic          in_range;

  // scan accumulators
  logic [SW-1:0] idx;
  logic          hit;
  logic [SW-1:0] hit_idx;
  logic          lru_found;
  logic [SW-1:0] lru_idx;
  logic [63:0]   lru_stamp;
  logic          free_found;
  logic [SW-1:0] free_idx;

  logic [VARIANT_CAP-1:0] cur_sv;

  assign addr     = key[AW-1:0];
  assign in_range = (32'(key) < NUM_KEYS);
  assign cur_sv   = rd_live ? rd_row.sv : '0;

  assign sts.scan_last = (idx == SW'(VARIANT_CAP - 1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
    end else if (cfg_we) begin
      enabled <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key       <= in_key;
      fp        <= in_print;
      bypass    <= in_bypass;
      replay_ok <= in_replay_ok;
      cstat     <= in_cstat;
    end
  end

  // one pass over the slots of the key's row
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      idx        <= '0;
      hit        <= 1'b0;
      hit_idx    <= '0;
      lru_found  <= 1'b0;
      lru_idx    <= '0;
      lru_stamp  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) idx <= idx + SW'(1);
      if (cur_sv[idx]) begin
        if (!hit && rd_row.sp[idx] == fp) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end
        if (!lru_found || rd_row.ss[idx] < lru_stamp) begin
          lru_found <= 1'b1;
          lru_idx   <= idx;
          lru_stamp <= rd_row.ss[idx];
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

  // decision
  row_t          nrow;
  logic          do_write;
  logic          bump;
  logic [1:0]    r_action;
  logic [SW+1:0] r_slot;
  logic          r_ev;
  logic [SW+1:0] r_ev_slot;
  logic          r_dead;
  logic          may;
  logic [SW-1:0] fill;

  always_comb begin
    nrow        = rd_row;
    nrow.dead   = rd_live & rd_row.dead;
    nrow.run    = rd_live ? rd_row.run : 2'd0;
    nrow.pvalid = rd_live & rd_row.pvalid;
    nrow.sv     = cur_sv;
    do_write    = 1'b0;
    bump        = 1'b0;
    r_action    = ACT_DIRECT;
    r_slot      = '0;
    r_ev        = 1'b0;
    r_ev_slot   = '0;
    r_dead      = nrow.dead;
    may         = 1'b0;
    fill        = free_idx;
    if (!in_range) begin
      r_dead = 1'b0;
    end else if (enabled && !bypass) begin
      do_write = 1'b1;
      if (!nrow.dead && hit) begin
        if (replay_ok) begin
          bump                 = 1'b1;
          nrow.ss[hit_idx]     = use_clock + 64'd1;
          nrow.pvalid          = 1'b0;
          r_action             = ACT_REPLAY;
          r_slot               = {2'b00, hit_idx};
        end else begin
          nrow.dead = 1'b1;
          r_dead    = 1'b1;
        end
      end else begin
        if (nrow.run != RUN_MAX) nrow.run = nrow.run + 2'd1;
        may = !nrow.dead && nrow.run[1];
        if (may && (&cur_sv)) begin
          if (nrow.pvalid && nrow.pprint == fp) begin
            // second consecutive miss: drop the LRU variant, refill there
            nrow.sv[lru_idx] = 1'b0;
            nrow.pvalid      = 1'b0;
            r_ev             = 1'b1;
            r_ev_slot        = {2'b00, lru_idx};
            fill             = lru_idx;
          end else begin
            nrow.pprint = fp;
            nrow.pvalid = 1'b1;
            may         = 1'b0;
          end
        end
        if (may) begin
          if (cstat == CST_ABORT) begin
            nrow.dead = 1'b1;
            r_dead    = 1'b1;
            r_action  = ACT_ABORT;
          end else if (cstat != CST_OK) begin
            nrow.dead = 1'b1;
            r_dead    = 1'b1;
          end else begin
            bump          = 1'b1;
            nrow.sv[fill] = 1'b1;
            nrow.sp[fill] = fp;
            nrow.ss[fill] = use_clock + 64'd1;
            nrow.pvalid   = 1'b0;
            r_action      = ACT_CAPTURE;
            r_slot        = {2'b00, fill};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= mem[addr];
    if (cmd.commit && do_write) mem[addr] <= nrow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      rd_live   <= 1'b0;
      use_clock <= '0;
    end else begin
      rd_live <= live[addr];
      if (cmd.commit && do_write) live[addr] <= 1'b1;
      if (cmd.commit && bump) use_clock <= use_clock + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action  <= r_action;
      out_slot    <= r_slot[1:0];
      out_evicted <= r_ev;
      out_ev_slot <= r_ev_slot[1:0];
      out_dead    <= r_dead;
    end
  end

endmodule

[hw/rtl/keyed_variant_cache_policy.sv]
// ----------------------------------------------------------------------------
// keyed_variant_cache_policy
// Per-key variant cache policy: replay, capture or direct, with LRU eviction.
// ----------------------------------------------------------------------------
// One request at a time. From accept to result a request passes through the
// per-key row read, a scan of the variant slots (four by default) one by one
// for a fingerprint match, the LRU victim and the first free slot, and a
// decide step that writes the row back. The result sits in an output
// register, so the next request is accepted while it waits; that request then
// stalls in its decide state until the register frees. State is cleared by
// per-key live bits at reset; no clearing pass. cache_enabled writes are taken
// at any time (ready is 1).
`timescale 1ns / 1ps

module keyed_variant_cache_policy #(
  parameter int NUM_KEYS    = 256,
  parameter int VARIANT_CAP = 4
) (
  input logic        clk,
  input logic        rst,
  kvc_req_if.sink    req,
  kvc_rsp_if.source  rsp,
  kvc_cfg_if.sink    cfg
);
  import kvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  kvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvc_datapath #(
    .NUM_KEYS    (NUM_KEYS),
    .VARIANT_CAP (VARIANT_CAP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .in_key       (req.key_index),
    .in_print     (req.fingerprint),
    .in_bypass    (req.bypass),
    .in_replay_ok (req.replay_ok),
    .in_cstat     (req.capture_status),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_action   (rsp.action),
    .out_slot     (rsp.slot),
    .out_evicted  (rsp.evicted),
    .out_ev_slot  (rsp.evicted_slot),
    .out_dead     (rsp.key_dead)
  );

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit did not present a result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> !req.ready)
    else $error("request taken while one is in flight");

  a_replay_live: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.action == ACT_REPLAY) |-> !rsp.key_dead)
    else $error("replay reported on a dead key");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed variant cache policy: a behavioral model
// predicts each response beat, which is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kvc_pkg::*;

  localparam int KEYS = 256;
  localparam int CAP  = 4;
  localparam int LONG_HOLD = 200;
  localparam logic [1:0] CST_FAIL = 2'd1;
  localparam logic [1:0] CST_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] slot;
    logic       evicted;
    logic [1:0] evicted_slot;
    logic       key_dead;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kvc_req_if req ();
  kvc_rsp_if rsp ();
  kvc_cfg_if cfg ();

  keyed_variant_cache_policy DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always #2 clk = ~clk;

  // model state
  logic        m_enabled;
  logic        m_dead [KEYS];
  logic [1:0]  m_runs [KEYS];
  logic        m_pend_v [KEYS];
  logic [63:0] m_pend_fp [KEYS];
  logic        m_sv [KEYS][CAP];
  logic [63:0] m_sfp [KEYS][CAP];
  logic [63:0] m_stamp [KEYS][CAP];
  logic [63:0] m_clock;

  verdict_t expected_verdicts[$];
  int mismatches = 0;
  int hold_off = 0;
  int hold_token = 0;
  int hold_seen = 0;
  bit stall_enable = 1'b1;

  function automatic verdict_t predict_verdict(logic [7:0] key, logic [63:0] fp,
                                               logic byp, logic rok,
                                               logic [1:0] cst);
    verdict_t v;
    bit may_cap;
    int cnt;
    int lru;
    bit found;
    int fill;
    v = '0;
    if (!m_enabled || byp) begin
      v.key_dead = m_dead[key];
      return v;
    end
    if (!m_dead[key]) begin
      for (int i = 0; i < CAP; i++) begin
        if (m_sv[key][i] && m_sfp[key][i] == fp) begin
          if (rok) begin
            m_clock++;
            m_stamp[key][i] = m_clock;
            m_pend_v[key] = 1'b0;
            v.action = ACT_REPLAY;
            v.slot = i[1:0];
          end else begin
            m_dead[key] = 1'b1;
            v.key_dead = 1'b1;
          end
          return v;
        end
      end
    end
    if (m_runs[key] < RUN_MAX) m_runs[key]++;
    may_cap = !m_dead[key] && m_runs[key] >= 2'd2;
    cnt = 0;
    for (int i = 0; i < CAP; i++) if (m_sv[key][i]) cnt++;
    if (may_cap && cnt >= CAP) begin
      if (m_pend_v[key] && m_pend_fp[key] == fp) begin
        lru = 0;
        found = 1'b0;
        for (int i = 0; i < CAP; i++) begin
          if (m_sv[key][i] && (!found || m_stamp[key][i] < m_stamp[key][lru])) begin
            lru = i;
            found = 1'b1;
          end
        end
        m_sv[key][lru] = 1'b0;
        m_pend_v[key] = 1'b0;
        v.evicted = 1'b1;
        v.evicted_slot = lru[1:0];
      end else begin
        m_pend_fp[key] = fp;
        m_pend_v[key] = 1'b1;
        may_cap = 1'b0;
      end
    end
    if (!may_cap) begin
      v.key_dead = m_dead[key];
      return v;
    end
    if (cst != CST_OK) begin
      m_dead[key] = 1'b1;
      v.key_dead = 1'b1;
      v.action = (cst == CST_ABORT) ? ACT_ABORT : ACT_DIRECT;
      return v;
    end
    fill = 0;
    for (int i = CAP - 1; i >= 0; i--) if (!m_sv[key][i]) fill = i;
    m_clock++;
    m_sv[key][fill] = 1'b1;
    m_sfp[key][fill] = fp;
    m_stamp[key][fill] = m_clock;
    m_pend_v[key] = 1'b0;
    v.action = ACT_CAPTURE;
    v.slot = fill[1:0];
    return v;
  endfunction

  // valid drops only when a real gap follows
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    req.valid <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk);
  endtask

  task automatic send_request(logic [7:0] key, logic [63:0] fp, logic byp,
                              logic rok, logic [1:0] cst, bit gaps = 1'b1);
    verdict_t v;
    if (gaps) idle_gap();
    req.valid <= 1'b1;
    req.key_index <= key;
    req.fingerprint <= fp;
    req.bypass <= byp;
    req.replay_ok <= rok;
    req.capture_status <= cst;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    v = predict_verdict(key, fp, byp, rok, cst);
    expected_verdicts = {expected_verdicts, v};
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(logic val);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    m_enabled = val;
  endtask

  // response side: random stalls, occasional long ones, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_off <= LONG_HOLD;
      rsp.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else if (!stall_enable) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 2) hold_off <= $urandom_range(8, 30);
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp_v;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.action, rsp.slot, rsp.evicted, rsp.evicted_slot, rsp.key_dead};
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat %h", got);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp act=%0d slot=%0d ev=%0d evs=%0d dead=%0d got act=%0d slot=%0d ev=%0d evs=%0d dead=%0d",
                     exp_v.action, exp_v.slot, exp_v.evicted, exp_v.evicted_slot,
                     exp_v.key_dead, got.action, got.slot, got.evicted,
                     got.evicted_slot, got.key_dead);
        end
      end
    end
  end

  // test: capture, replay, fill, eviction hysteresis and every failure kind
  task automatic test_directed();
    send_request(8'd0, 64'h0, 1'b0, 1'b1, CST_OK);
    send_request(8'd0, 64'h0, 1'b0, 1'b1, CST_OK);          // capture slot 0
    send_request(8'd0, 64'h0, 1'b0, 1'b1, CST_OK);          // replay
    for (int i = 1; i < CAP; i++)
      send_request(8'd0, {64{1'b1}} - i, 1'b0, 1'b1, CST_OK);
    send_request(8'd0, {64{1'b1}}, 1'b0, 1'b1, CST_OK);     // pending
    send_request(8'd0, {64{1'b1}}, 1'b0, 1'b1, CST_OK);     // evicts lru
    send_request(8'd0, 64'h5, 1'b0, 1'b1, CST_OK);
    send_request(8'd0, 64'h5, 1'b0, 1'b1, CST_ABORT);       // evict + abort
    send_request(8'd0, 64'h0, 1'b0, 1'b1, CST_OK);          // dead key
    send_request(8'd255, 64'h7, 1'b1, 1'b0, CST_FAIL);      // bypass
    send_request(8'd255, 64'h7, 1'b0, 1'b0, CST_FAIL);
    send_request(8'd255, 64'h7, 1'b0, 1'b0, CST_FAIL);      // capture failure
    send_request(8'd1, 64'h9, 1'b0, 1'b0, CST_OK);
    send_request(8'd1, 64'h9, 1'b0, 1'b0, CST_OK);
    send_request(8'd1, 64'h9, 1'b0, 1'b0, CST_OK);          // replay failure
    send_request(8'd2, 64'h9, 1'b0, 1'b0, CST_BAD);
    send_request(8'd2, 64'h9, 1'b0, 1'b0, CST_BAD);         // undefined status
  endtask

  task automatic random_block(int n);
    logic [7:0] key;
    logic [63:0] fp;
    logic [1:0] cst;
    int r;
    for (int i = 0; i < n; i++) begin
      // few keys and a small fingerprint pool so hits and misses both happen
      key = $urandom_range(0, 99) < 85 ? 8'($urandom_range(3, 10)) : 8'($urandom);
      fp = $urandom_range(0, 99) < 85 ? 64'($urandom_range(0, 6)) << 60 | 64'h1
                                      : {$urandom, $urandom};
      r = $urandom_range(0, 99);
      cst = r < 94 ? CST_OK : (r < 96 ? CST_FAIL : (r < 98 ? CST_ABORT : CST_BAD));
      send_request(key, fp, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 97, cst);
    end
  endtask

  task automatic test_random();
    random_block(300);
    write_enable(1'b0);
    random_block(30);
    write_enable(1'b1);
    random_block(300);
  endtask

  // test: response side held off while requests keep coming, then never stalled
  task automatic test_backpressure();
    drain();
    hold_token++;
    for (int i = 0; i < 12; i++)
      send_request(8'(20 + i % 3), 64'(i % 5), 1'b0, 1'b1, CST_OK, 1'b0);
    drain();
    stall_enable = 1'b0;
    for (int i = 0; i < 12; i++)
      send_request(8'(30 + i % 2), 64'(i % 6), 1'b0, 1'b1, CST_OK, 1'b0);
    stall_enable = 1'b1;
  endtask

  initial begin
    req.valid = 1'b0;
    req.key_index = '0;
    req.fingerprint = '0;
    req.bypass = 1'b0;
    req.replay_ok = 1'b0;
    req.capture_status = CST_OK;
    cfg.valid = 1'b0;
    cfg.data = 1'b1;
    m_enabled = 1'b1;
    m_clock = '0;
    for (int k = 0; k < KEYS; k++) begin
      m_dead[k] = 1'b0;
      m_runs[k] = '0;
      m_pend_v[k] = 1'b0;
      m_pend_fp[k] = '0;
      for (int s = 0; s < CAP; s++) begin
        m_sv[k][s] = 1'b0;
        m_sfp[k][s] = '0;
        m_stamp[k][s] = '0;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_enable(1'b1);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
